### hdl/omr_pkg.sv
// ----------------------------------------------------------------------------
// omr_pkg: shared constants and types for the ohmmeter ratio and formatter
// Field widths, arithmetic limits, register indexes and point codes.
// ----------------------------------------------------------------------------
package omr_pkg;

  localparam int V_W     = 13;
  localparam int R_W     = 16;
  localparam int VK_W    = 20;
  localparam int NUM_W   = 36;
  localparam int DEN_W   = 13;
  localparam int RES_W   = 34;
  localparam int BIN_W   = 20;
  localparam int NDIG    = 6;
  localparam int DIG_W   = 4;
  localparam int CFG_W   = 16;

  localparam logic [V_W-1:0]   VREF_MV        = 13'd5000;
  localparam logic [V_W-1:0]   GUARD_MV       = 13'd4999;
  localparam logic [RES_W-1:0] GUARD_VALUE    = 34'd65535;
  localparam logic [RES_W-1:0] OVER_LIMIT     = 34'd1000000;
  localparam logic [RES_W-1:0] FINE_LIMIT     = 34'd10000;
  localparam logic [R_W-1:0]   HIGH_REF_RESET = 16'd10000;
  localparam logic [V_W-1:0]   FINE_THR_RESET = 13'd147;

  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_HIGH_REF = 1'b0;
  localparam reg_idx_t REG_FINE_THR = 1'b1;

  typedef logic [1:0] point_t;
  localparam point_t PT_0 = 2'd0;
  localparam point_t PT_1 = 2'd1;
  localparam point_t PT_2 = 2'd2;
  localparam point_t PT_3 = 2'd3;

  typedef logic [DIG_W-1:0] digit_t;

endpackage

### hdl/ohmmeter_ratio_and_display_format.sv
// ----------------------------------------------------------------------------
// ohmmeter_ratio_and_display_format: resistance ratio and 3-digit formatter
// R = ref*v*k/(5000-v) via serial multiply and divide, then BCD formatting.
// ----------------------------------------------------------------------------
// Steps: serial multiply, serial divide, then BCD conversion; a voltage guard
//   hit skips the multiply and divide.
// One transaction is in flight at a time: a new input is taken only once the
//   previous result has moved to the output register.
// A new input is taken while the previous result waits on the output.
// Reset (rst, synchronous): idle, no result pending, registers at defaults,
//   fine scale flag cleared.
module ohmmeter_ratio_and_display_format
  import omr_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  omr_pkg::reg_idx_t           wr_index,
  input  logic [omr_pkg::CFG_W-1:0]   wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [omr_pkg::V_W-1:0]     divider_mv,
  input  logic [omr_pkg::R_W-1:0]     reference_ohm,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [omr_pkg::RES_W-1:0]   resistance_scaled,
  output logic                        fine_scale,
  output omr_pkg::digit_t             digit_first,
  output omr_pkg::digit_t             digit_second,
  output omr_pkg::digit_t             digit_third,
  output omr_pkg::point_t             point_code,
  output logic                        out_of_range,
  output logic                        guard_hit
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_DIV  = 6'b000100,
    S_CHK  = 6'b001000,
    S_BCD  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [R_W-1:0]    high_ref;
  logic [V_W-1:0]    fine_thr;
  logic              fine;
  logic [V_W-1:0]    v_q;
  logic              guard_q;
  logic              over_q;
  logic [RES_W-1:0]  r_q;

  logic              accept;
  logic              guard_in;
  logic              fine_in;
  logic [VK_W-1:0]   vk;
  logic              mul_start;
  logic              mul_done;
  logic [NUM_W-1:0]  prod;
  logic              div_start;
  logic              div_done;
  logic [NUM_W-1:0]  quo;
  logic              bcd_start;
  logic              bcd_done;
  digit_t [NDIG-1:0] bd;
  logic              out_load;

  digit_t            d1;
  digit_t            d2;
  digit_t            d3;
  digit_t            t;
  digit_t            u;
  point_t            pt;
  logic              lt1k;
  logic              lt10k;
  logic              lt100k;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign guard_in  = divider_mv >= GUARD_MV;
  assign fine_in   = (divider_mv < fine_thr) && (reference_ohm != high_ref);
  assign vk        = fine_in ? VK_W'(divider_mv) * VK_W'(100)
                             : VK_W'(divider_mv) * VK_W'(10);
  assign mul_start = accept && !guard_in;
  assign div_start = (state == S_MUL) && mul_done;
  assign bcd_start = (state == S_CHK);
  assign out_load  = (state == S_OUT) && (!out_valid || out_ready);

  omr_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (reference_ohm),
    .b     (vk),
    .done  (mul_done),
    .prod  (prod)
  );

  omr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod),
    .den   (VREF_MV - v_q),
    .done  (div_done),
    .quo   (quo)
  );

  omr_bcd u_bcd (
    .clk    (clk),
    .rst    (rst),
    .start  (bcd_start),
    .bin    (r_q[BIN_W-1:0]),
    .done   (bcd_done),
    .digits (bd)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = guard_in ? S_CHK : S_MUL;
      S_MUL:  if (mul_done) state_next = S_DIV;
      S_DIV:  if (div_done) state_next = S_CHK;
      S_CHK:  state_next = S_BCD;
      S_BCD:  if (bcd_done) state_next = S_OUT;
      S_OUT:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      high_ref <= HIGH_REF_RESET;
      fine_thr <= FINE_THR_RESET;
      fine     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        unique case (wr_index)
          REG_HIGH_REF: high_ref <= wr_data;
          REG_FINE_THR: fine_thr <= wr_data[V_W-1:0];
          default: ;
        endcase
      end
      if (accept && !guard_in) begin
        fine <= fine_in;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      v_q     <= divider_mv;
      guard_q <= guard_in;
      r_q     <= GUARD_VALUE;
    end
    if ((state == S_DIV) && div_done) begin
      r_q <= quo[RES_W-1:0];
    end
    if (state == S_CHK) begin
      over_q <= (r_q == '0) || (r_q >= OVER_LIMIT) || (fine && (r_q >= FINE_LIMIT));
    end
  end

  assign lt1k   = (bd[5] == '0) && (bd[4] == '0) && (bd[3] == '0);
  assign lt10k  = (bd[5] == '0) && (bd[4] == '0);
  assign lt100k = (bd[5] == '0);

  always_comb begin
    d1 = '0;
    d2 = '0;
    d3 = '0;
    t  = '0;
    u  = '0;
    pt = PT_3;
    if (!over_q) begin
      if (lt1k) begin
        d1 = bd[2];
        d2 = bd[1];
        d3 = bd[0];
        pt = PT_1;
      end else begin
        if (lt10k) begin
          d1 = bd[3]; d2 = bd[2]; t = bd[1]; u = bd[0];
          pt = fine ? PT_2 : PT_3;
        end else if (lt100k) begin
          d1 = bd[4]; d2 = bd[3]; t = bd[2]; u = bd[1];
          pt = PT_0;
        end else begin
          d1 = bd[5]; d2 = bd[4]; t = bd[3]; u = bd[2];
          pt = PT_1;
        end
        d3 = t + DIG_W'(u >= DIG_W'(6));
        if (d3 == DIG_W'(10)) begin
          d3 = '0;
          d2 = d2 + DIG_W'(1);
        end
        if (d2 == DIG_W'(10)) begin
          d2 = '0;
          d1 = d1 + DIG_W'(1);
        end
        if (d1 == DIG_W'(10)) begin
          d1 = DIG_W'(1);
          pt = (pt == PT_3) ? PT_1 : pt + PT_1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      resistance_scaled <= r_q;
      fine_scale        <= fine;
      digit_first       <= d1;
      digit_second      <= d2;
      digit_third       <= d3;
      point_code        <= pt;
      out_of_range      <= over_q;
      guard_hit         <= guard_q;
    end
  end

endmodule

### hdl/omr_mul.sv
// ----------------------------------------------------------------------------
// omr_mul: bit-serial shift-add multiplier
// One multiplier bit per cycle; done pulses after the last bit.
// ----------------------------------------------------------------------------
module omr_mul
  import omr_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [omr_pkg::R_W-1:0]       a,
  input  logic [omr_pkg::VK_W-1:0]      b,
  output logic                          done,
  output logic [omr_pkg::NUM_W-1:0]     prod
);
  localparam int CNT_W = $clog2(R_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] acc;
  logic [NUM_W-1:0] mcand;
  logic [R_W-1:0]   mplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(R_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= NUM_W'(b);
      mplier <= a;
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

  assign prod = acc;

endmodule

### hdl/omr_div.sv
// ----------------------------------------------------------------------------
// omr_div: restoring bit-serial divider
// One quotient bit per cycle, most significant first.
// ----------------------------------------------------------------------------
module omr_div
  import omr_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [omr_pkg::NUM_W-1:0]     num,
  input  logic [omr_pkg::DEN_W-1:0]     den,
  output logic                          done,
  output logic [omr_pkg::NUM_W-1:0]     quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dsr;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem, quo[NUM_W-1]};
  assign ge    = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= den;
      quo <= num;
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

endmodule

### hdl/omr_bcd.sv
// ----------------------------------------------------------------------------
// omr_bcd: serial binary to BCD converter
// Double dabble, one binary bit shifted in per cycle.
// ----------------------------------------------------------------------------
module omr_bcd
  import omr_pkg::*;
(
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [omr_pkg::BIN_W-1:0]          bin,
  output logic                               done,
  output omr_pkg::digit_t [omr_pkg::NDIG-1:0] digits
);
  localparam int CNT_W = $clog2(BIN_W + 1);

  logic                     busy;
  logic [CNT_W-1:0]         cnt;
  logic [BIN_W-1:0]         sh;
  digit_t [NDIG-1:0]        adj;
  logic [NDIG*DIG_W-1:0]    adj_flat;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i] = (digits[i] >= DIG_W'(5)) ? digits[i] + DIG_W'(3) : digits[i];
    end
  end

  assign adj_flat = adj;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(BIN_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh     <= bin;
      digits <= '0;
    end else if (busy) begin
      digits <= {adj_flat[NDIG*DIG_W-2:0], sh[BIN_W-1]};
      sh     <= sh << 1;
    end
  end

endmodule

### hdl/omr_checker.sv
// ----------------------------------------------------------------------------
// omr_checker: port-level checks for the ohmmeter formatter
// Watches the result channel and the formatting invariants.
// ----------------------------------------------------------------------------
module omr_checker
  import omr_pkg::*;
(
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [omr_pkg::RES_W-1:0]   resistance_scaled,
  input logic                        fine_scale,
  input omr_pkg::digit_t             digit_first,
  input omr_pkg::digit_t             digit_second,
  input omr_pkg::digit_t             digit_third,
  input omr_pkg::point_t             point_code,
  input logic                        out_of_range,
  input logic                        guard_hit
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transaction");

  a_over: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> digit_first == '0 && digit_second == '0
      && digit_third == '0 && point_code == PT_3)
    else $error("over-range display not blank");

  a_guard: assert property (@(posedge clk) disable iff (rst)
    out_valid && guard_hit |-> resistance_scaled == GUARD_VALUE)
    else $error("guard value wrong");

  a_digits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> digit_first <= 4'd9 && digit_second <= 4'd9 && digit_third <= 4'd9)
    else $error("digit out of decimal range");

  a_fine: assert property (@(posedge clk) disable iff (rst)
    out_valid && fine_scale && !out_of_range |-> resistance_scaled < FINE_LIMIT)
    else $error("fine scale value too large");

endmodule

bind ohmmeter_ratio_and_display_format omr_checker u_omr_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .resistance_scaled (resistance_scaled),
  .fine_scale        (fine_scale),
  .digit_first       (digit_first),
  .digit_second      (digit_second),
  .digit_third       (digit_third),
  .point_code        (point_code),
  .out_of_range      (out_of_range),
  .guard_hit         (guard_hit)
);

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: ohmmeter ratio and display format
// Drives divider voltage and reference readings through a queue-fed driver,
// predicts resistance, scale flag, digits and point code, and checks every
// output transaction in order. Registers are rewritten between phases while
// the block is idle; the sender and receiver idle at varying rates.
// ----------------------------------------------------------------------------
module testbench;
  import omr_pkg::*;

  typedef struct packed {
    logic [V_W-1:0] mv;
    logic [R_W-1:0] ohm;
  } reading_t;

  typedef struct packed {
    logic [RES_W-1:0] res;
    logic             fine;
    digit_t           d1;
    digit_t           d2;
    digit_t           d3;
    point_t           pt;
    logic             over;
    logic             guard;
  } display_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  reg_idx_t wr_index = REG_HIGH_REF;
  logic [CFG_W-1:0] wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [V_W-1:0] divider_mv = '0;
  logic [R_W-1:0] reference_ohm = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [RES_W-1:0] resistance_scaled;
  logic fine_scale;
  digit_t digit_first, digit_second, digit_third;
  point_t point_code;
  logic out_of_range, guard_hit;

  ohmmeter_ratio_and_display_format dut (.*);

  always #4 clk = ~clk;

  reading_t pending_readings[$];
  display_t expected_displays[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_off_armed = 1'b0;
  int hold_off_cycles = 0;
  int errors = 0;

  logic [R_W-1:0] high_ref_model = HIGH_REF_RESET;
  logic [V_W-1:0] fine_thr_model = FINE_THR_RESET;
  logic           fine_model = 1'b0;

  function automatic display_t predict_display(reading_t rd);
    display_t e;
    logic [63:0] r;
    logic [31:0] x, f1, f2, den, d1, d2, d3;
    logic [1:0] pt;
    e = '0;
    pt = PT_3;
    d1 = 0; d2 = 0; d3 = 0;
    if (rd.mv >= GUARD_MV) begin
      e.guard = 1'b1;
      r = 64'd65535;
    end else begin
      fine_model = (rd.mv < fine_thr_model) && (rd.ohm != high_ref_model);
      r = (64'(rd.ohm) * 64'(rd.mv) * (fine_model ? 64'd100 : 64'd10)) /
          64'(5000 - rd.mv);
    end
    r = r & 64'h3_FFFF_FFFF;
    if (r == 0 || r >= 1000000 || (fine_model && r >= 10000)) begin
      e.over = 1'b1;
    end else begin
      x = 32'(r);
      if (x < 1000) begin
        f1 = 100; pt = PT_1;
      end else if (x < 10000) begin
        f1 = 1000; pt = fine_model ? PT_2 : PT_3;
      end else if (x < 100000) begin
        f1 = 10000; pt = PT_0;
      end else begin
        f1 = 100000; pt = PT_1;
      end
      f2 = f1 / 10;
      den = (f1 == 100) ? 1 : f1 / 1000;
      d1 = x / f1;
      d2 = (x % f1) / f2;
      d3 = (x % f2) / den;
      if (f1 != 100) begin
        d3 = (d3 + 4) / 10;
        if (d3 == 10) begin
          d3 = 0; d2++;
        end
        if (d2 == 10) begin
          d2 = 0; d1++;
        end
        if (d1 == 10) begin
          d1 = 1;
          pt = (pt == PT_3) ? PT_1 : pt + 2'd1;
        end
      end
    end
    e.res = r[RES_W-1:0];
    e.fine = fine_model;
    e.d1 = d1[3:0];
    e.d2 = d2[3:0];
    e.d3 = d3[3:0];
    e.pt = pt;
    return e;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        expected_displays.push_back(predict_display({divider_mv, reference_ohm}));
      end
      if (pending_readings.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        {divider_mv, reference_ohm} <= pending_readings.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    display_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_displays.size() == 0) begin
        $display("unexpected output transaction");
        errors++;
      end else begin
        e = expected_displays.pop_front();
        if (resistance_scaled !== e.res) report_mismatch("resistance", resistance_scaled, e.res);
        if (fine_scale !== e.fine) report_mismatch("fine_scale", fine_scale, e.fine);
        if (digit_first !== e.d1) report_mismatch("digit_first", digit_first, e.d1);
        if (digit_second !== e.d2) report_mismatch("digit_second", digit_second, e.d2);
        if (digit_third !== e.d3) report_mismatch("digit_third", digit_third, e.d3);
        if (point_code !== e.pt) report_mismatch("point_code", point_code, e.pt);
        if (out_of_range !== e.over) report_mismatch("out_of_range", out_of_range, e.over);
        if (guard_hit !== e.guard) report_mismatch("guard_hit", guard_hit, e.guard);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off_armed && hold_off_cycles < 2000) begin
      hold_off_cycles <= hold_off_cycles + 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic add_reading(int mv, int ohm);
    reading_t rd;
    rd.mv = mv[V_W-1:0];
    rd.ohm = ohm[R_W-1:0];
    pending_readings.push_back(rd);
  endtask

  task automatic add_random(int n);
    int mv;
    repeat (n) begin
      case ($urandom_range(5))
        0: mv = $urandom_range(8191);
        1: mv = $urandom_range(fine_thr_model + 2);
        2: mv = $urandom_range(5000, 4990);
        default: mv = $urandom_range(4998);
      endcase
      if ($urandom_range(7) == 0) add_reading(mv, high_ref_model);
      else if ($urandom_range(3) == 0) add_reading(mv, $urandom_range(2000));
      else add_reading(mv, $urandom_range(65535));
    end
  endtask

  task automatic drain();
    while (pending_readings.size() > 0 || in_valid || expected_displays.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int value);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= value[CFG_W-1:0];
    @(posedge clk);
    wr_en <= 1'b0;
    if (idx == REG_HIGH_REF) high_ref_model = value[R_W-1:0];
    else fine_thr_model = value[V_W-1:0];
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    add_reading(0, 0);
    add_reading(8191, 65535);
    add_reading(4999, 100);
    add_reading(4998, 65535);
    add_reading(4998, 1);
    add_reading(1, 1);
    add_reading(100, 10000);
    add_reading(100, 1000);
    add_reading(146, 500);
    add_reading(147, 500);
    add_reading(5000, 500);
    add_reading(50, 1);
    add_reading(4000, 250);
    add_reading(2500, 1000);
    add_reading(2500, 9996);
    add_reading(1, 9995);
    add_reading(4950, 1000);
    add_reading(4167, 1999);
    add_reading(4545, 9999);
    add_reading(4096, 43690);
    add_reading(2730, 21845);
    drain();
    send_idle_pct = 16; recv_idle_pct = 51;
    add_random(300);
    hold_off_armed <= 1'b1;
    drain();
    write_reg(REG_HIGH_REF, 0);
    write_reg(REG_FINE_THR, 5000);
    send_idle_pct = 51; recv_idle_pct = 16;
    add_random(250);
    drain();
    write_reg(REG_HIGH_REF, 65535);
    write_reg(REG_FINE_THR, 0);
    add_random(150);
    drain();
    write_reg(REG_HIGH_REF, 1000);
    write_reg(REG_FINE_THR, 4096);
    send_idle_pct = 0; recv_idle_pct = 0;
    add_random(300);
    drain();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### ohmmeter_ratio_and_display_format.f
hdl/omr_pkg.sv
hdl/omr_mul.sv
hdl/omr_div.sv
hdl/omr_bcd.sv
hdl/ohmmeter_ratio_and_display_format.sv
hdl/omr_checker.sv
bench/testbench.sv
